### hw/rtl/mefd_pkg.sv
// ----------------------------------------------------------------------------
// mefd_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU energy-meter frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mefd_pkg;

	localparam int unsigned FrameLen  = 25;
	localparam int unsigned CrcSpan   = 23;
	localparam int unsigned CountBits = 5;

	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;

	typedef enum logic [1:0] {
		ST_IGNORED  = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_OK       = 2'd2
	} status_t;

	// packed from the top down: status ends up in the lowest bits
	typedef struct packed {
		logic [5:0]  pad;
		logic [15:0] crc_received;
		logic [15:0] crc_computed;
		logic [15:0] power_factor;
		logic [15:0] frequency;
		logic [31:0] power;
		logic [31:0] current;
		logic [15:0] voltage;
		status_t     status;
	} result_t;

	localparam int unsigned ResultBits = $bits(result_t);

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/modbus_energy_frame_decoder.sv
// ----------------------------------------------------------------------------
// modbus_energy_frame_decoder
// Checks a Modbus RTU energy-meter response byte by byte (CRC-16/MODBUS over
// bytes 0..22 against bytes 23..24) and reports the measurement words.
//
//   channel  dir  payload
//   s_axis   in   tdata[7:0] data_byte, tlast buffer_end
//   m_axis   out  tdata[151:0] status, voltage, current, power, frequency,
//                 power_factor, crc_computed, crc_received
//
// One byte per cycle, unless a frame-closing byte is held back. A byte sits
// in the input register, where the CRC byte update and field capture run;
// a frame-closing byte then lands in the result register. Reset clears
// counters and frame state. A waiting result stalls only a frame-closing
// byte in the input register; other bytes keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_energy_frame_decoder (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	input  wire logic [7:0]    s_axis_tdata,  // [7:0] data_byte
	input  wire logic          s_axis_tlast,  // buffer_end
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// [1:0] status, [17:2] voltage, [49:18] current, [81:50] power,
	// [97:82] frequency, [113:98] power_factor, [129:114] crc_computed,
	// [145:130] crc_received, [151:146] zero
	output logic [151:0]       m_axis_tdata
);
	import mefd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       go;
	result_t    result;
	result_t    out_data;

	assign go            = valid_s1 && (!last_s1 || room);
	assign s_axis_tready = !valid_s1 || go;
	assign m_axis_tdata  = 152'(out_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	mefd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go),
		.data_byte  (byte_s1),
		.buffer_end (last_s1),
		.result     (result)
	);

	mefd_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (go && last_s1),
		.result (result),
		.room   (room),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (out_data)
	);

endmodule

`default_nettype wire

### hw/rtl/mefd_frame.sv
// ----------------------------------------------------------------------------
// mefd_frame
// Per-frame state: byte count, running CRC and the captured fields.
// Builds the result for the byte that closes a buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mefd_frame (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        data_byte,
	input  wire logic              buffer_end,
	output mefd_pkg::result_t      result
);
	import mefd_pkg::*;

	localparam logic [CountBits-1:0] IdxFunc  = CountBits'(1);
	localparam logic [CountBits-1:0] IdxVoltH = CountBits'(3);
	localparam logic [CountBits-1:0] IdxVoltL = CountBits'(4);
	localparam logic [CountBits-1:0] IdxCur0  = CountBits'(5);
	localparam logic [CountBits-1:0] IdxCur1  = CountBits'(6);
	localparam logic [CountBits-1:0] IdxCur2  = CountBits'(7);
	localparam logic [CountBits-1:0] IdxCur3  = CountBits'(8);
	localparam logic [CountBits-1:0] IdxPow0  = CountBits'(9);
	localparam logic [CountBits-1:0] IdxPow1  = CountBits'(10);
	localparam logic [CountBits-1:0] IdxPow2  = CountBits'(11);
	localparam logic [CountBits-1:0] IdxPow3  = CountBits'(12);
	localparam logic [CountBits-1:0] IdxFreqH = CountBits'(17);
	localparam logic [CountBits-1:0] IdxFreqL = CountBits'(18);
	localparam logic [CountBits-1:0] IdxPfH   = CountBits'(19);
	localparam logic [CountBits-1:0] IdxPfL   = CountBits'(20);
	localparam logic [CountBits-1:0] IdxCrcL  = CountBits'(23);
	localparam logic [CountBits-1:0] IdxCrcH  = CountBits'(24);
	localparam logic [CountBits-1:0] CountMax = '1;

	logic [CountBits-1:0] count_q, count_n;
	logic [15:0]          crc_q, crc_n;
	logic [7:0]           func_q, func_n;
	logic [15:0]          volt_q, volt_n;
	logic [31:0]          cur_q, cur_n;
	logic [31:0]          pow_q, pow_n;
	logic [15:0]          freq_q, freq_n;
	logic [15:0]          pf_q, pf_n;
	logic [15:0]          rx_crc_q, rx_crc_n;

	always_comb begin
		crc_n    = (count_q < CountBits'(CrcSpan)) ? crc16_byte(crc_q, data_byte) : crc_q;
		func_n   = func_q;
		volt_n   = volt_q;
		cur_n    = cur_q;
		pow_n    = pow_q;
		freq_n   = freq_q;
		pf_n     = pf_q;
		rx_crc_n = rx_crc_q;
		unique case (count_q)
			IdxFunc:  func_n          = data_byte;
			IdxVoltH: volt_n[15:8]    = data_byte;
			IdxVoltL: volt_n[7:0]     = data_byte;
			IdxCur0:  cur_n[15:8]     = data_byte;
			IdxCur1:  cur_n[7:0]      = data_byte;
			IdxCur2:  cur_n[31:24]    = data_byte;
			IdxCur3:  cur_n[23:16]    = data_byte;
			IdxPow0:  pow_n[15:8]     = data_byte;
			IdxPow1:  pow_n[7:0]      = data_byte;
			IdxPow2:  pow_n[31:24]    = data_byte;
			IdxPow3:  pow_n[23:16]    = data_byte;
			IdxFreqH: freq_n[15:8]    = data_byte;
			IdxFreqL: freq_n[7:0]     = data_byte;
			IdxPfH:   pf_n[15:8]      = data_byte;
			IdxPfL:   pf_n[7:0]       = data_byte;
			IdxCrcL:  rx_crc_n[7:0]   = data_byte;
			IdxCrcH:  rx_crc_n[15:8]  = data_byte;
			default: ;
		endcase
		count_n = (count_q != CountMax) ? count_q + CountBits'(1) : count_q;
	end

	always_comb begin
		result = '0;
		if (count_n >= CountBits'(FrameLen) && func_n == FUNC_READ_INPUT) begin
			result.crc_computed = crc_n;
			result.crc_received = rx_crc_n;
			if (crc_n == rx_crc_n) begin
				result.status       = ST_OK;
				result.voltage      = volt_n;
				result.current      = cur_n;
				result.power        = pow_n;
				result.frequency    = freq_n;
				result.power_factor = pf_n;
			end else begin
				result.status = ST_MISMATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			crc_q    <= CRC_INIT;
			func_q   <= '0;
			volt_q   <= '0;
			cur_q    <= '0;
			pow_q    <= '0;
			freq_q   <= '0;
			pf_q     <= '0;
			rx_crc_q <= '0;
		end else if (step) begin
			if (buffer_end) begin
				count_q  <= '0;
				crc_q    <= CRC_INIT;
				func_q   <= '0;
				volt_q   <= '0;
				cur_q    <= '0;
				pow_q    <= '0;
				freq_q   <= '0;
				pf_q     <= '0;
				rx_crc_q <= '0;
			end else begin
				count_q  <= count_n;
				crc_q    <= crc_n;
				func_q   <= func_n;
				volt_q   <= volt_n;
				cur_q    <= cur_n;
				pow_q    <= pow_n;
				freq_q   <= freq_n;
				pf_q     <= pf_n;
				rx_crc_q <= rx_crc_n;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mefd_out.sv
// ----------------------------------------------------------------------------
// mefd_out
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module mefd_out (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire mefd_pkg::result_t    result,
	output logic                      room,
	output logic                      tvalid,
	input  wire logic                 tready,
	output mefd_pkg::result_t         tdata
);
	import mefd_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign room   = !valid_q || tready;
	assign tvalid = valid_q;
	assign tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (room && push) begin
			data_q <= result;
		end
	end

endmodule

`default_nettype wire
